FILE: hdl/mmsdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmsdf_pkg
// Shared types, codes and helpers of the media packet deframer.
// ----------------------------------------------------------------------------
package mmsdf_pkg;

   localparam logic [15:0] MAX_PACKET_LEN_RESET = 16'd4096;

   // pre-header markers
   localparam logic [7:0] MEDIA_MARK = 8'h04;
   localparam logic [7:0] SIG_B4     = 8'hce;
   localparam logic [7:0] SIG_B5     = 8'hfa;
   localparam logic [7:0] SIG_B6     = 8'h0b;
   localparam logic [7:0] SIG_B7     = 8'hb0;
   localparam logic [15:0] PRE_HDR_LEN = 16'd8;

   // command codes
   localparam logic [15:0] CMD_PING   = 16'h001b;
   localparam logic [15:0] CMD_END    = 16'h001e;
   localparam logic [15:0] CMD_IGNORE = 16'h0005;

   localparam logic [31:0] CMD_OFS_LO   = 32'd24;
   localparam logic [31:0] CMD_OFS_HI   = 32'd25;
   localparam logic [31:0] BODY_EXTRA   = 32'd4;

   typedef enum logic [2:0] {
      PH_PRE,
      PH_SKIP,
      PH_PAY,
      PH_LEN,
      PH_BODY
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EVENT   = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      EV_PING    = 2'd0,
      EV_END     = 2'd1,
      EV_IGNORE  = 2'd2,
      EV_UNKNOWN = 2'd3
   } event_type;

   typedef enum logic {
      ERR_SIGNATURE = 1'b0,
      ERR_SHORT_LEN = 1'b1
   } error_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      event_type  event_code;
      error_type  error_code;
      logic [15:0] pad_count;
      logic       last;
   } result_type;

   function automatic event_type event_of(input logic [15:0] code);
      event_type ev;
      if (code == CMD_PING) begin
         ev = EV_PING;
      end else if (code == CMD_END) begin
         ev = EV_END;
      end else if (code == CMD_IGNORE) begin
         ev = EV_IGNORE;
      end else begin
         ev = EV_UNKNOWN;
      end
      return ev;
   endfunction

endpackage

FILE: hdl/mms_media_packet_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mms_media_packet_deframer_core
// Byte-serial deframer for a media stream: media payload and command events.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one received stream byte per request (tdata[7:0]).
//   rsp_*  : zero or one result per request. tuser carries the kind
//            (payload byte, command event, error), tlast marks the last
//            payload byte of a media packet, whose pad_count is the number
//            of zero bytes that fill the packet up to max_packet_len.
//   csr_*  : writes max_packet_len; write it only while the block is idle.
//   A result is registered: it is on rsp in the cycle after its request is taken.
//   Throughput: one byte per cycle; the frame state and the result register
//   are the only stored stages, so a byte enters on every cycle in which
//   the result register is empty or being drained.
//   When the receiver stalls, the held result stays on rsp and req_tready
//   drops until it is taken.
//   Reset (synchronous): parser returns to the pre-header, the result
//   register empties, max_packet_len returns to 4096.
// ----------------------------------------------------------------------------
module mms_media_packet_deframer_core
   import mmsdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [7:0] payload_byte, [9:8] event_code,
                                     // [10] error_code, [26:11] pad_count
   output logic [1:0]  rsp_tuser,    // [1:0] kind
   output logic        rsp_tlast,    // last payload byte
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata     // max_packet_len
);

   logic [15:0] max_packet_len_ff;
   logic        slot_free;
   logic        in_accept;
   logic        res_valid;
   result_type  res;

   assign csr_ready  = 1'b1;
   assign req_tready = slot_free;
   assign in_accept  = req_tvalid && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_packet_len_ff <= MAX_PACKET_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         max_packet_len_ff <= csr_wdata;
      end
   end

   mmsdf_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .in_accept      (in_accept),
      .in_byte        (req_tdata),
      .max_packet_len (max_packet_len_ff),
      .res_valid      (res_valid),
      .res            (res)
   );

   mmsdf_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (in_accept),
      .res_valid  (res_valid),
      .res        (res),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: hdl/mmsdf_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmsdf_parser
// Frame state machine: takes one byte per accepted request and forms the
// result that byte causes, if any.
// ----------------------------------------------------------------------------
module mmsdf_parser
   import mmsdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_accept,
   input  logic [7:0]  in_byte,
   input  logic [15:0] max_packet_len,
   output logic        res_valid,
   output result_type  res
);

   phase_type   phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [7:0]  b4_ff, b4_in;
   logic [7:0]  b5_ff, b5_in;
   logic [7:0]  b6_ff, b6_in;
   logic [31:0] body_len_ff, body_len_in;
   logic [15:0] skip_ff, skip_in;
   logic [15:0] cmd_ff, cmd_in;

   logic [31:0] count_inc;
   logic [15:0] raw_len;
   logic [15:0] media_len;
   logic [15:0] skip_dec;
   logic [31:0] len_full;

   assign count_inc = count_ff + 32'd1;
   assign raw_len   = {in_byte, b6_ff};
   assign media_len = raw_len - PRE_HDR_LEN;
   assign skip_dec  = skip_ff - 16'd1;
   assign len_full  = {in_byte, body_len_ff[23:0]} + BODY_EXTRA;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      b4_in       = b4_ff;
      b5_in       = b5_ff;
      b6_in       = b6_ff;
      body_len_in = body_len_ff;
      skip_in     = skip_ff;
      cmd_in      = cmd_ff;
      res_valid   = 1'b0;
      res         = '0;

      case (phase_ff)
         PH_PRE: begin
            count_in = count_inc;
            case (count_ff[2:0])
               3'd4: b4_in = in_byte;
               3'd5: b5_in = in_byte;
               3'd6: b6_in = in_byte;
               default: ;
            endcase
            if (count_ff[2:0] == 3'd7) begin
               count_in = '0;
               if (b4_ff == MEDIA_MARK) begin
                  if (raw_len < PRE_HDR_LEN) begin
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.error_code = ERR_SHORT_LEN;
                     phase_in       = PH_PRE;
                  end else if (media_len > max_packet_len) begin
                     // leading excess is dropped
                     skip_in     = media_len - max_packet_len;
                     body_len_in = {16'd0, max_packet_len};
                     phase_in    = PH_SKIP;
                  end else begin
                     skip_in     = '0;
                     body_len_in = {16'd0, media_len};
                     phase_in    = (media_len != 16'd0) ? PH_PAY : PH_PRE;
                  end
               end else if (in_byte != SIG_B7 || b6_ff != SIG_B6 ||
                            b5_ff != SIG_B5 || b4_ff != SIG_B4) begin
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_SIGNATURE;
                  phase_in       = PH_PRE;
               end else begin
                  body_len_in = '0;
                  phase_in    = PH_LEN;
               end
            end
         end
         PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == 16'd0) begin
               count_in = '0;
               phase_in = (body_len_ff != 32'd0) ? PH_PAY : PH_PRE;
            end
         end
         PH_PAY: begin
            count_in         = count_inc;
            res_valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = in_byte;
            if (count_inc >= body_len_ff) begin
               res.last      = 1'b1;
               res.pad_count = (max_packet_len > body_len_ff[15:0]) ?
                               (max_packet_len - body_len_ff[15:0]) : 16'd0;
               count_in      = '0;
               phase_in      = PH_PRE;
            end
         end
         PH_LEN: begin
            count_in = count_inc;
            case (count_ff[1:0])
               2'd0: body_len_in[7:0]   = in_byte;
               2'd1: body_len_in[15:8]  = in_byte;
               2'd2: body_len_in[23:16] = in_byte;
               default: begin
                  body_len_in = len_full;
                  count_in    = '0;
                  cmd_in      = '0;
                  if (len_full == 32'd0) begin
                     // empty body: code reads as zero
                     res_valid      = 1'b1;
                     res.kind       = KIND_EVENT;
                     res.event_code = event_of(16'd0);
                     phase_in       = PH_PRE;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            endcase
         end
         PH_BODY: begin
            count_in = count_inc;
            if (count_ff == CMD_OFS_LO) begin
               cmd_in[7:0] = in_byte;
            end else if (count_ff == CMD_OFS_HI) begin
               cmd_in[15:8] = in_byte;
            end
            if (count_inc == body_len_ff) begin
               res_valid      = 1'b1;
               res.kind       = KIND_EVENT;
               res.event_code = event_of(cmd_in);
               count_in       = '0;
               phase_in       = PH_PRE;
            end
         end
         default: begin
            count_in = '0;
            phase_in = PH_PRE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_PRE;
         count_ff    <= '0;
         body_len_ff <= '0;
         skip_ff     <= '0;
         cmd_ff      <= '0;
      end else if (in_accept) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         body_len_ff <= body_len_in;
         skip_ff     <= skip_in;
         cmd_ff      <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         b4_ff <= b4_in;
         b5_ff <= b5_in;
         b6_ff <= b6_in;
      end
   end

`ifndef SYNTH
   a_pre_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PRE |-> count_ff < 32'd8)
      else $error("pre-header count out of range");

   a_len_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LEN |-> count_ff < 32'd4)
      else $error("length field count out of range");

   a_pay_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAY |-> (body_len_ff != 32'd0 && body_len_ff[31:16] == 16'd0))
      else $error("payload length invalid");

   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> skip_ff != 16'd0)
      else $error("skip phase with nothing to skip");
`endif

endmodule

FILE: hdl/mmsdf_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmsdf_out_reg
// Result register and response channel packing.
// ----------------------------------------------------------------------------
module mmsdf_out_reg
   import mmsdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic        res_valid,
   input  result_type  res,
   output logic        slot_free,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   logic       valid_ff;
   result_type res_ff;

   // free when empty or the held result leaves this cycle
   assign slot_free = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= res_valid;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, res_ff.pad_count, res_ff.error_code,
                        res_ff.event_code, res_ff.payload_byte};
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tlast  = res_ff.last;

`ifndef SYNTH
   a_last_is_payload: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && res_ff.last) |-> res_ff.kind == KIND_PAYLOAD)
      else $error("last flag on a non-payload result");

   a_pad_only_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !res_ff.last) |-> res_ff.pad_count == 16'd0)
      else $error("pad count on a non-last result");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte-stream check of the media packet deframer: a directed run of error,
// wrap and resync frames, then random media, command, broken and noise
// frames under several packet sizes and handshake idle patterns. Each
// result is checked against a cycle-free model of the frame parser or a preset.
// ----------------------------------------------------------------------------
module testbench;
   import mmsdf_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int RAND_PHASES    = 8;
   localparam int PHASE_BYTES    = 165;
   localparam int RX_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES  = 4;

   // idle patterns: sender idle percent, receiver stall percent
   localparam int IDLE_NONE = 0;
   localparam int IDLE_TX   = 1;
   localparam int IDLE_RX   = 2;
   localparam int IDLE_BOTH = 3;

   localparam logic FROM_MODEL = 1'b0;
   localparam logic PRESET     = 1'b1;

   localparam result_type NO_RESULT   = '0;
   localparam result_type SIG_ERROR   =
      '{KIND_ERROR, 8'h00, EV_PING, ERR_SIGNATURE, 16'h0000, 1'b0};
   localparam result_type SHORT_ERROR =
      '{KIND_ERROR, 8'h00, EV_PING, ERR_SHORT_LEN, 16'h0000, 1'b0};
   localparam result_type WRAP_EVENT  =
      '{KIND_EVENT, 8'h00, EV_UNKNOWN, ERR_SIGNATURE, 16'h0000, 1'b0};

   typedef struct packed {
      logic [7:0] rx;
      logic       preset;
      result_type want;
   } stim_row_type;

   // bad signature, media length below eight, command length that wraps to 0
   localparam stim_row_type DIRECTED_STIM [28] = '{
      '{8'h00, FROM_MODEL, NO_RESULT}, '{8'h00, FROM_MODEL, NO_RESULT},
      '{8'h00, FROM_MODEL, NO_RESULT}, '{8'h00, FROM_MODEL, NO_RESULT},
      '{8'hce, FROM_MODEL, NO_RESULT}, '{8'hfa, FROM_MODEL, NO_RESULT},
      '{8'h0b, FROM_MODEL, NO_RESULT}, '{8'hb1, PRESET,     SIG_ERROR},
      '{8'hff, FROM_MODEL, NO_RESULT}, '{8'hff, FROM_MODEL, NO_RESULT},
      '{8'hff, FROM_MODEL, NO_RESULT}, '{8'hff, FROM_MODEL, NO_RESULT},
      '{8'h04, FROM_MODEL, NO_RESULT}, '{8'hff, FROM_MODEL, NO_RESULT},
      '{8'h07, FROM_MODEL, NO_RESULT}, '{8'h00, PRESET,     SHORT_ERROR},
      '{8'h80, FROM_MODEL, NO_RESULT}, '{8'h7f, FROM_MODEL, NO_RESULT},
      '{8'h01, FROM_MODEL, NO_RESULT}, '{8'hfe, FROM_MODEL, NO_RESULT},
      '{8'hce, FROM_MODEL, NO_RESULT}, '{8'hfa, FROM_MODEL, NO_RESULT},
      '{8'h0b, FROM_MODEL, NO_RESULT}, '{8'hb0, FROM_MODEL, NO_RESULT},
      '{8'hfc, FROM_MODEL, NO_RESULT}, '{8'hff, FROM_MODEL, NO_RESULT},
      '{8'hff, FROM_MODEL, NO_RESULT}, '{8'hff, PRESET,     WRAP_EVENT}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [7:0] payload_byte, [9:8] event_code,
                              // [10] error_code, [26:11] pad_count
   logic [1:0]  rsp_tuser;    // [1:0] kind
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_wdata;    // max_packet_len

   // parser model state
   phase_type   df_phase;
   logic [31:0] df_count;
   logic [31:0] df_hdr;
   logic [31:0] df_body_len;
   logic [15:0] df_skip;
   logic [15:0] df_cmd;
   logic [15:0] pkt_max_len;

   result_type  pending_results [$];
   logic [7:0]  frame_bytes [$];
   int          bad_results = 0;
   int          cycle_count = 0;
   int          tx_idle_pct = 0;
   int          rx_stall_pct = 0;
   int          hold_asks = 0;
   int          hold_done = 0;

   mms_media_packet_deframer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model
   function automatic void goto_preheader();
      df_phase = PH_PRE;
      df_count = '0;
      df_hdr   = '0;
   endfunction

   function automatic void close_command(output result_type r);
      r = '0;
      r.kind = KIND_EVENT;
      if (df_cmd == CMD_PING) begin
         r.event_code = EV_PING;
      end else if (df_cmd == CMD_END) begin
         r.event_code = EV_END;
      end else if (df_cmd == CMD_IGNORE) begin
         r.event_code = EV_IGNORE;
      end else begin
         r.event_code = EV_UNKNOWN;
      end
      goto_preheader();
   endfunction

   function automatic bit deframe_byte(input logic [7:0] b, output result_type r);
      logic [15:0] raw;
      logic [15:0] len;
      bit          hit;
      r   = '0;
      hit = 1'b0;
      case (df_phase)
         PH_PRE: begin
            if (df_count == 0) df_hdr = '0;
            if (df_count >= 4 && df_count < 8) df_hdr[8*(df_count-4) +: 8] = b;
            df_count++;
            if (df_count == 8) begin
               df_count = '0;
               if (df_hdr[7:0] == MEDIA_MARK) begin
                  raw = df_hdr[31:16];
                  if (raw < PRE_HDR_LEN) begin
                     goto_preheader();
                     r.kind       = KIND_ERROR;
                     r.error_code = ERR_SHORT_LEN;
                     hit          = 1'b1;
                  end else begin
                     len     = raw - PRE_HDR_LEN;
                     df_skip = '0;
                     if (len > pkt_max_len) begin
                        df_skip = len - pkt_max_len;
                        len     = pkt_max_len;
                     end
                     df_body_len = 32'(len);
                     if (df_skip != 0) df_phase = PH_SKIP;
                     else if (len != 0) df_phase = PH_PAY;
                     else goto_preheader();
                  end
               end else if (df_hdr != {SIG_B7, SIG_B6, SIG_B5, SIG_B4}) begin
                  goto_preheader();
                  r.kind       = KIND_ERROR;
                  r.error_code = ERR_SIGNATURE;
                  hit          = 1'b1;
               end else begin
                  df_body_len = '0;
                  df_phase    = PH_LEN;
               end
            end
         end
         PH_SKIP: begin
            if (df_skip != 0) df_skip--;
            if (df_skip == 0) begin
               if (df_body_len != 0) begin
                  df_phase = PH_PAY;
                  df_count = '0;
               end else begin
                  goto_preheader();
               end
            end
         end
         PH_PAY: begin
            df_count++;
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = b;
            hit            = 1'b1;
            if (df_count >= df_body_len) begin
               r.last      = 1'b1;
               // pad saturates when the size shrank under an open packet
               r.pad_count = (32'(pkt_max_len) > df_body_len) ?
                             16'(32'(pkt_max_len) - df_body_len) : 16'd0;
               goto_preheader();
            end
         end
         PH_LEN: begin
            df_body_len[8*df_count[1:0] +: 8] = b;
            df_count++;
            if (df_count >= 4) begin
               df_body_len = df_body_len + BODY_EXTRA;
               df_count    = '0;
               df_cmd      = '0;
               if (df_body_len == 0) begin
                  close_command(r);
                  hit = 1'b1;
               end else begin
                  df_phase = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            if (df_count == CMD_OFS_LO) df_cmd[7:0] = b;
            else if (df_count == CMD_OFS_HI) df_cmd[15:8] = b;
            df_count++;
            if (df_count == df_body_len) begin
               close_command(r);
               hit = 1'b1;
            end
         end
         default: goto_preheader();
      endcase
      return hit;
   endfunction

   // ------------------------------------------------------------ stimulus
   task automatic set_idle(input int mode);
      case (mode)
         IDLE_TX:   begin tx_idle_pct = 75; rx_stall_pct = 0;  end
         IDLE_RX:   begin tx_idle_pct = 0;  rx_stall_pct = 75; end
         IDLE_BOTH: begin tx_idle_pct = 23; rx_stall_pct = 23; end
         default:   begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b, input logic preset,
                            input result_type want);
      result_type r;
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (deframe_byte(b, r) || preset) begin
         pending_results.push_back(preset ? want : r);
      end
   endtask

   // drop valid, drain all results, then let the block sit quiet
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pkt_max_len = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic build_frame();
      int          pick;
      int          body;
      int          i;
      logic [15:0] raw;
      logic [15:0] code;
      logic [31:0] field;
      logic [31:0] sig;
      pick = $urandom_range(99);
      repeat (4) frame_bytes.push_back(8'($urandom_range(255)));
      if (pick < 45) begin
         // media packet; a few long ones reach past small packet sizes
         if ($urandom_range(19) == 0) raw = 16'(256 + $urandom_range(40));
         else if ($urandom_range(9) == 0) raw = PRE_HDR_LEN;
         else raw = 16'(8 + $urandom_range(40));
         frame_bytes.push_back(MEDIA_MARK);
         frame_bytes.push_back(8'($urandom_range(255)));
         frame_bytes.push_back(raw[7:0]);
         frame_bytes.push_back(raw[15:8]);
         repeat (raw - PRE_HDR_LEN) frame_bytes.push_back(8'($urandom_range(255)));
      end else if (pick < 80) begin
         frame_bytes.push_back(SIG_B4);
         frame_bytes.push_back(SIG_B5);
         frame_bytes.push_back(SIG_B6);
         frame_bytes.push_back(SIG_B7);
         body  = $urandom_range(40);
         field = 32'(body) - BODY_EXTRA;
         for (i = 0; i < 4; i++) frame_bytes.push_back(field[8*i +: 8]);
         case ($urandom_range(4))
            0:       code = CMD_PING;
            1:       code = CMD_END;
            2:       code = CMD_IGNORE;
            3:       code = {8'h00, 8'($urandom_range(255))};
            default: code = 16'($urandom_range(65535));
         endcase
         for (i = 0; i < body; i++) begin
            if (i == CMD_OFS_LO) frame_bytes.push_back(code[7:0]);
            else if (i == CMD_OFS_HI) frame_bytes.push_back(code[15:8]);
            else frame_bytes.push_back(8'($urandom_range(255)));
         end
      end else if (pick < 86) begin
         frame_bytes.push_back(MEDIA_MARK);
         frame_bytes.push_back(8'($urandom_range(255)));
         frame_bytes.push_back(8'($urandom_range(7)));
         frame_bytes.push_back(8'h00);
      end else if (pick < 96) begin
         sig = {SIG_B7, SIG_B6, SIG_B5, SIG_B4};
         i   = $urandom_range(3);
         sig[8*i +: 8] = sig[8*i +: 8] ^ 8'($urandom_range(1, 255));
         for (i = 0; i < 4; i++) frame_bytes.push_back(sig[8*i +: 8]);
      end else begin
         // cut frame: throws the parser out of step with the frames that follow
         repeat ($urandom_range(5)) frame_bytes.push_back(8'($urandom_range(255)));
      end
   endtask

   // ------------------------------------------------------------- receiver
   initial begin : rx_side
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_done) begin
            rsp_tready <= 1'b0;
            for (n = 0; n < RX_HOLD_CYCLES; n++) @(negedge clock);
            hold_done++;
         end
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // -------------------------------------------------------------- checker
   task automatic log_bad(input string what, input result_type want,
                          input result_type got);
      bad_results++;
      if (bad_results <= 10) begin
         $display("%s: want kind=%0d byte=%02h ev=%0d err=%0d pad=%0d last=%0b",
                  what, want.kind, want.payload_byte, want.event_code,
                  want.error_code, want.pad_count, want.last);
         $display("   got kind=%0d byte=%02h ev=%0d err=%0d pad=%0d last=%0b",
                  got.kind, got.payload_byte, got.event_code,
                  got.error_code, got.pad_count, got.last);
      end
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind         = kind_type'(rsp_tuser);
         got.payload_byte = rsp_tdata[7:0];
         got.event_code   = event_type'(rsp_tdata[9:8]);
         got.error_code   = error_type'(rsp_tdata[10]);
         got.pad_count    = rsp_tdata[26:11];
         got.last         = rsp_tlast;
         if (pending_results.size() == 0) begin
            log_bad("result with nothing pending", NO_RESULT, got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) log_bad("result mismatch", want, got);
         end
      end
   end

   // ----------------------------------------------------------------- main
   initial begin : stimulus
      int             k;
      int             p;
      logic [15:0]    sizes [RAND_PHASES];
      result_type     none;
      none       = NO_RESULT;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_wdata  = '0;
      pkt_max_len = MAX_PACKET_LEN_RESET;
      df_body_len = '0;
      df_skip     = '0;
      df_cmd      = '0;
      goto_preheader();

      // phase 0 keeps the reset size
      sizes[0] = MAX_PACKET_LEN_RESET;
      sizes[1] = 16'hffff;
      sizes[2] = 16'd0;
      sizes[3] = 16'd24;
      sizes[4] = 16'd1;
      sizes[5] = 16'($urandom_range(2, 40));
      sizes[6] = 16'($urandom_range(65535));
      sizes[7] = 16'd12;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idle(IDLE_NONE);
      for (k = 0; k < 28; k++) begin
         send_byte(DIRECTED_STIM[k].rx, DIRECTED_STIM[k].preset, DIRECTED_STIM[k].want);
      end

      for (p = 0; p < RAND_PHASES; p++) begin
         settle();
         if (p != 0) write_max_len(sizes[p]);
         set_idle(p % 4);
         // long receiver hold with the sender still pushing
         if (p == 0) hold_asks++;
         repeat (PHASE_BYTES) begin
            if (frame_bytes.size() == 0) build_frame();
            send_byte(frame_bytes.pop_front(), FROM_MODEL, none);
         end
      end

      settle();
      if (bad_results == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
